FILE: hw/rtl/rtqi_pkg.sv
// types, constants and step table for the ray-triangle intersection block
`default_nettype none
package rtqi_pkg;

    localparam int COORD_W = 16;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int OPB_W   = 36;
    localparam int ACC_W   = 56;
    localparam int DIST_W  = 31;
    localparam int NSTEPS  = 24;

    localparam logic [1:0] CFG_QUAD_MODE = 2'd0;
    localparam logic [1:0] CFG_DET_EPS   = 2'd1;
    localparam logic [1:0] CFG_T_EPS     = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CAST = 1'b1;

    // operand a selects
    localparam logic [3:0] A_DIR = 4'd0;
    localparam logic [3:0] A_TV  = 4'd3;
    localparam logic [3:0] A_E1  = 4'd6;
    localparam logic [3:0] A_E2  = 4'd9;
    // operand b selects
    localparam logic [3:0] B_E1  = 4'd0;
    localparam logic [3:0] B_E2  = 4'd3;
    localparam logic [3:0] B_PV  = 4'd6;
    localparam logic [3:0] B_QV  = 4'd9;
    // result slots
    localparam logic [3:0] R_PV  = 4'd0;
    localparam logic [3:0] R_QV  = 4'd3;
    localparam logic [3:0] R_DET = 4'd6;
    localparam logic [3:0] R_UN  = 4'd7;
    localparam logic [3:0] R_VN  = 4'd8;
    localparam logic [3:0] R_TN  = 4'd9;

    typedef struct packed {
        logic        mode;
        logic [1:0]  vertex_slot;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } rtqi_in_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] hit_distance;
    } rtqi_out_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dst;
    } rtqi_uop_t;

    function automatic rtqi_uop_t mk(input logic [3:0] a, input logic [3:0] b, input logic n,
                                     input logic f, input logic l, input logic [3:0] d);
        rtqi_uop_t u;
        u.valid = 1'b1;
        u.a_sel = a;
        u.b_sel = b;
        u.neg   = n;
        u.first = f;
        u.last  = l;
        u.dst   = d;
        return u;
    endfunction

    // cross products first, then the four dot products
    function automatic rtqi_uop_t uop(input logic [4:0] step);
        rtqi_uop_t u;
        u = '0;
        case (step)
            5'd0:  u = mk(A_DIR + 4'd1, B_E2 + 4'd2, 1'b0, 1'b1, 1'b0, R_PV);
            5'd1:  u = mk(A_DIR + 4'd2, B_E2 + 4'd1, 1'b1, 1'b0, 1'b1, R_PV);
            5'd2:  u = mk(A_DIR + 4'd2, B_E2,        1'b0, 1'b1, 1'b0, R_PV + 4'd1);
            5'd3:  u = mk(A_DIR,        B_E2 + 4'd2, 1'b1, 1'b0, 1'b1, R_PV + 4'd1);
            5'd4:  u = mk(A_DIR,        B_E2 + 4'd1, 1'b0, 1'b1, 1'b0, R_PV + 4'd2);
            5'd5:  u = mk(A_DIR + 4'd1, B_E2,        1'b1, 1'b0, 1'b1, R_PV + 4'd2);
            5'd6:  u = mk(A_TV + 4'd1,  B_E1 + 4'd2, 1'b0, 1'b1, 1'b0, R_QV);
            5'd7:  u = mk(A_TV + 4'd2,  B_E1 + 4'd1, 1'b1, 1'b0, 1'b1, R_QV);
            5'd8:  u = mk(A_TV + 4'd2,  B_E1,        1'b0, 1'b1, 1'b0, R_QV + 4'd1);
            5'd9:  u = mk(A_TV,         B_E1 + 4'd2, 1'b1, 1'b0, 1'b1, R_QV + 4'd1);
            5'd10: u = mk(A_TV,         B_E1 + 4'd1, 1'b0, 1'b1, 1'b0, R_QV + 4'd2);
            5'd11: u = mk(A_TV + 4'd1,  B_E1,        1'b1, 1'b0, 1'b1, R_QV + 4'd2);
            5'd12: u = mk(A_E1,         B_PV,        1'b0, 1'b1, 1'b0, R_DET);
            5'd13: u = mk(A_E1 + 4'd1,  B_PV + 4'd1, 1'b0, 1'b0, 1'b0, R_DET);
            5'd14: u = mk(A_E1 + 4'd2,  B_PV + 4'd2, 1'b0, 1'b0, 1'b1, R_DET);
            5'd15: u = mk(A_TV,         B_PV,        1'b0, 1'b1, 1'b0, R_UN);
            5'd16: u = mk(A_TV + 4'd1,  B_PV + 4'd1, 1'b0, 1'b0, 1'b0, R_UN);
            5'd17: u = mk(A_TV + 4'd2,  B_PV + 4'd2, 1'b0, 1'b0, 1'b1, R_UN);
            5'd18: u = mk(A_DIR,        B_QV,        1'b0, 1'b1, 1'b0, R_VN);
            5'd19: u = mk(A_DIR + 4'd1, B_QV + 4'd1, 1'b0, 1'b0, 1'b0, R_VN);
            5'd20: u = mk(A_DIR + 4'd2, B_QV + 4'd2, 1'b0, 1'b0, 1'b1, R_VN);
            5'd21: u = mk(A_E2,         B_QV,        1'b0, 1'b1, 1'b0, R_TN);
            5'd22: u = mk(A_E2 + 4'd1,  B_QV + 4'd1, 1'b0, 1'b0, 1'b0, R_TN);
            5'd23: u = mk(A_E2 + 4'd2,  B_QV + 4'd2, 1'b0, 1'b0, 1'b1, R_TN);
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ray_triangle_quad_intersect_top.sv
// ray-triangle and ray-quad intersection with one shared multiplier and divider
// load transfer: writes the addressed vertex slot, no result
// cast transfer: per triangle a setup state, the multiply-accumulate steps, sign fix and test,
// then the divide; in quad mode a second triangle follows when the first misses; the divider
// yields one quotient bit per cycle; one item at a time
// reset: synchronous active low, vertices zero, quad_mode 0, det_epsilon 16, t_epsilon 0
`default_nettype none
module ray_triangle_quad_intersect_top
    import rtqi_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire rtqi_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output rtqi_out_t       m_data,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [30:0] cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_MULT = 7'b0000100,
        ST_NEG  = 7'b0001000,
        ST_CMP  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_RESP = 7'b1000000
    } state_t;

    state_t state_reg;

    logic        quad_mode_reg;
    logic [15:0] det_eps_reg;
    logic [30:0] t_eps_reg;

    logic signed [COORD_W-1:0] vs_reg [4][3];
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [EDGE_W-1:0]  tv_reg [3];
    logic signed [ACC_W-1:0]   res_reg [10];
    logic                      tri_reg;
    logic [4:0]                step_reg;
    rtqi_uop_t                 ctl_reg;
    logic signed [EDGE_W+OPB_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    logic signed [ACC_W-1:0]   det_reg, un_reg, vn_reg, tn_reg;
    logic [ACC_W-1:0]          rem_reg;
    logic [30:0]               dsh_reg;
    logic [30:0]               q_reg;
    logic [4:0]                cnt_reg;

    logic                      m_valid_reg;
    rtqi_out_t                 m_data_reg;

    logic signed [EDGE_W-1:0]  a_ops [12];
    logic signed [OPB_W-1:0]   b_ops [12];
    logic signed [EDGE_W+OPB_W-1:0] mul_out;
    rtqi_uop_t                 cur_uop;

    logic [1:0] vb, vc;
    logic       s_fire;

    logic signed [ACC_W:0] uv_sum;
    logic cmp_pass, cmp_ovf;
    logic [ACC_W:0] r2;
    logic [ACC_W:0] r2_sub;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign vb = tri_reg ? 2'd2 : 2'd1;
    assign vc = tri_reg ? 2'd3 : 2'd2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_ops[A_DIR + i] = EDGE_W'(dir_reg[i]);
            a_ops[A_TV + i]  = tv_reg[i];
            a_ops[A_E1 + i]  = e1_reg[i];
            a_ops[A_E2 + i]  = e2_reg[i];
            b_ops[B_E1 + i]  = OPB_W'(e1_reg[i]);
            b_ops[B_E2 + i]  = OPB_W'(e2_reg[i]);
            b_ops[B_PV + i]  = res_reg[R_PV + i][OPB_W-1:0];
            b_ops[B_QV + i]  = res_reg[R_QV + i][OPB_W-1:0];
        end
    end

    assign cur_uop = uop(step_reg);
    assign mul_out = a_ops[cur_uop.a_sel] * b_ops[cur_uop.b_sel];

    always_comb begin
        acc_next = ctl_reg.first ? '0 : acc_reg;
        if (ctl_reg.neg) begin
            acc_next = acc_next - ACC_W'(prod_reg);
        end else begin
            acc_next = acc_next + ACC_W'(prod_reg);
        end
    end

    assign uv_sum   = (ACC_W+1)'(un_reg) + (ACC_W+1)'(vn_reg);
    assign cmp_pass = (det_reg != '0)
                   && (det_reg >= ACC_W'($signed({1'b0, det_eps_reg})))
                   && !un_reg[ACC_W-1] && (un_reg <= det_reg)
                   && !vn_reg[ACC_W-1] && (uv_sum <= (ACC_W+1)'(det_reg))
                   && !tn_reg[ACC_W-1] && (tn_reg != '0);
    assign cmp_ovf  = (ACC_W'(tn_reg >>> 15) >= det_reg);

    assign r2     = {rem_reg, dsh_reg[30]};
    assign r2_sub = r2 - (ACC_W+1)'(unsigned'(det_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            quad_mode_reg <= 1'b0;
            det_eps_reg   <= 16'd16;
            t_eps_reg     <= '0;
            m_valid_reg   <= 1'b0;
            ctl_reg       <= '0;
            tri_reg       <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    vs_reg[i][j] <= '0;
                end
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_QUAD_MODE: quad_mode_reg <= cfg_wdata[0];
                    CFG_DET_EPS:   det_eps_reg   <= cfg_wdata[15:0];
                    CFG_T_EPS:     t_eps_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.mode == MODE_LOAD) begin
                            vs_reg[s_data.vertex_slot][0] <= s_data.point_x;
                            vs_reg[s_data.vertex_slot][1] <= s_data.point_y;
                            vs_reg[s_data.vertex_slot][2] <= s_data.point_z;
                        end else begin
                            org_reg[0] <= s_data.point_x;
                            org_reg[1] <= s_data.point_y;
                            org_reg[2] <= s_data.point_z;
                            dir_reg[0] <= s_data.dir_x;
                            dir_reg[1] <= s_data.dir_y;
                            dir_reg[2] <= s_data.dir_z;
                            tri_reg    <= 1'b0;
                            state_reg  <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= EDGE_W'(vs_reg[vb][i]) - EDGE_W'(vs_reg[0][i]);
                        e2_reg[i] <= EDGE_W'(vs_reg[vc][i]) - EDGE_W'(vs_reg[0][i]);
                        tv_reg[i] <= EDGE_W'(org_reg[i]) - EDGE_W'(vs_reg[0][i]);
                    end
                    step_reg  <= '0;
                    ctl_reg   <= '0;
                    state_reg <= ST_MULT;
                end
                ST_MULT: begin
                    prod_reg <= mul_out;
                    ctl_reg  <= cur_uop;
                    if (ctl_reg.valid) begin
                        acc_reg <= acc_next;
                        if (ctl_reg.last) begin
                            res_reg[ctl_reg.dst] <= acc_next;
                        end
                    end
                    if (step_reg == 5'(NSTEPS)) begin
                        state_reg <= ST_NEG;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_NEG: begin
                    if (res_reg[R_DET][ACC_W-1]) begin
                        det_reg <= -res_reg[R_DET];
                        un_reg  <= -res_reg[R_UN];
                        vn_reg  <= -res_reg[R_VN];
                        tn_reg  <= -res_reg[R_TN];
                    end else begin
                        det_reg <= res_reg[R_DET];
                        un_reg  <= res_reg[R_UN];
                        vn_reg  <= res_reg[R_VN];
                        tn_reg  <= res_reg[R_TN];
                    end
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    rem_reg <= ACC_W'(unsigned'(tn_reg >>> 15));
                    dsh_reg <= {tn_reg[14:0], 16'd0};
                    q_reg   <= '0;
                    cnt_reg <= '0;
                    if (cmp_pass && cmp_ovf) begin
                        m_data_reg.hit          <= 1'b1;
                        m_data_reg.hit_distance <= '1;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= ST_RESP;
                    end else if (cmp_pass) begin
                        state_reg <= ST_DIV;
                    end else if (quad_mode_reg && !tri_reg) begin
                        tri_reg   <= 1'b1;
                        state_reg <= ST_PREP;
                    end else begin
                        m_data_reg  <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_RESP;
                    end
                end
                ST_DIV: begin
                    dsh_reg <= {dsh_reg[29:0], 1'b0};
                    if (!r2_sub[ACC_W]) begin
                        rem_reg <= r2_sub[ACC_W-1:0];
                        q_reg   <= {q_reg[29:0], 1'b1};
                    end else begin
                        rem_reg <= r2[ACC_W-1:0];
                        q_reg   <= {q_reg[29:0], 1'b0};
                    end
                    if (cnt_reg == 5'(DIST_W - 1)) begin
                        if (q_reg != '0 || r2 >= (ACC_W+1)'(unsigned'(det_reg)) ||
                            t_eps_reg != '0) begin
                            // final quotient includes this cycle's bit
                            if ({q_reg[29:0], !r2_sub[ACC_W]} > t_eps_reg) begin
                                m_data_reg.hit          <= 1'b1;
                                m_data_reg.hit_distance <= {q_reg[29:0], !r2_sub[ACC_W]};
                                m_valid_reg             <= 1'b1;
                                state_reg               <= ST_RESP;
                            end else if (quad_mode_reg && !tri_reg) begin
                                tri_reg   <= 1'b1;
                                state_reg <= ST_PREP;
                            end else begin
                                m_data_reg  <= '0;
                                m_valid_reg <= 1'b1;
                                state_reg   <= ST_RESP;
                            end
                        end else if (quad_mode_reg && !tri_reg) begin
                            tri_reg   <= 1'b1;
                            state_reg <= ST_PREP;
                        end else begin
                            m_data_reg  <= '0;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_RESP;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_RESP: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
